// File: hdl/pclut_pkg.sv
package pclut_pkg;

    // Table size and derived level index limit
    localparam int LEVELS = 256;
    localparam int LEVEL_W = 8;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVELS - 1);

    // Divider sizing: |numerator| < 2^25, |denominator| <= 255
    localparam int NUM_W = 25;
    localparam int DEN_W = 8;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    // Result range in signed Q.8
    localparam int OUT_W = 24;
    localparam logic [NUM_W-1:0] OUT_MAX_Q = NUM_W'(8388607);
    localparam logic [NUM_W-1:0] OUT_MIN_MAG_Q = NUM_W'(8388608);
    localparam logic [OUT_W-1:0] OUT_MAX_V = 24'h7FFFFF;
    localparam logic [OUT_W-1:0] OUT_MIN_V = 24'h800000;
    localparam logic [OUT_W-1:0] MISSING_V = 24'hFFFF00;

    typedef enum logic [1:0] {
        OP_ACCUM   = 2'd0,
        OP_COMPUTE = 2'd1,
        OP_CLEAR   = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic prep;
        logic step;
        logic finish;
    } pclut_cmd_t;

    typedef struct packed {
        logic special;
        logic out_free;
    } pclut_status_t;

endpackage

// File: hdl/pclut_ctrl.sv
module pclut_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  logic [1:0]              s_opcode,
    output logic                    s_ready,
    input  pclut_pkg::pclut_status_t status,
    output pclut_pkg::pclut_cmd_t   cmd
);
    import pclut_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;

    // State and step counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Sequence one compute word: prepare, divide, write result
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        cmd = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && s_opcode == OP_COMPUTE) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                count_next = '0;
                state_next = status.special ? ST_FINISH : ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/pclut_datapath.sv
module pclut_datapath (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pclut_pkg::pclut_cmd_t     cmd,
    output pclut_pkg::pclut_status_t  status,
    input  logic [1:0]                s_opcode,
    input  logic [1:0]                s_channel,
    input  logic signed [8:0]         s_measured_level,
    input  logic signed [8:0]         s_cell_black,
    input  logic signed [8:0]         s_cell_level,
    input  logic [pclut_pkg::LEVEL_W-1:0] s_level_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [pclut_pkg::OUT_W-1:0] m_lut_value,
    output logic                      m_cell_missing,
    output logic                      m_divide_by_zero,
    output logic                      m_saturated
);
    import pclut_pkg::*;

    // Per-channel statistics
    logic [7:0] max_reg [4];
    logic [7:0] max_next [4];
    logic [7:0] min_reg [4];
    logic [7:0] min_next [4];

    // Operand registers
    logic signed [17:0] prod_reg, prod_next;
    logic signed [17:0] term_reg, term_next;
    logic miss_reg, miss_next;
    logic dz_reg, dz_next;
    logic den_neg_reg, den_neg_next;
    logic [DEN_W-1:0] den_abs_reg, den_abs_next;

    // Divider registers
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic neg_reg, neg_next;

    // Output word registers
    logic m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] lut_reg, lut_next;
    logic miss_out_reg, miss_out_next;
    logic dz_out_reg, dz_out_next;
    logic sat_out_reg, sat_out_next;

    logic [7:0] h_sel;
    logic [7:0] l_sel;
    logic [LEVEL_W-1:0] v_sel;
    logic signed [8:0] diff_hl;
    logic signed [9:0] l_cb;
    logic signed [9:0] den;
    logic signed [9:0] den_neg_v;
    logic signed [18:0] sum;
    logic signed [18:0] sum_neg;
    logic [16:0] sum_mag;
    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_diff;
    logic trial_ge;
    logic [NUM_W-1:0] quo_neg;
    logic [7:0] meas8;

    // Statistics: fold measurements in, restore on clear
    always_comb begin
        meas8 = s_measured_level[7:0];
        max_next = max_reg;
        min_next = min_reg;
        if (cmd.accept) begin
            case (s_opcode)
                OP_ACCUM: begin
                    if (!s_measured_level[8]) begin
                        if (meas8 > max_reg[s_channel]) max_next[s_channel] = meas8;
                        if (meas8 < min_reg[s_channel]) min_next[s_channel] = meas8;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < 4; i++) begin
                        max_next[i] = 8'd0;
                        min_next[i] = 8'd255;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Operand capture: product, offset term and denominator
    always_comb begin
        h_sel = min_reg[s_channel];
        l_sel = max_reg[0];
        v_sel = (32'(s_level_index) > LEVELS - 1) ? LEVEL_MAX : s_level_index;
        diff_hl = $signed({1'b0, h_sel}) - $signed({1'b0, l_sel});
        l_cb = $signed({2'b00, l_sel}) - $signed({s_cell_black[8], s_cell_black});
        den = $signed({s_cell_level[8], s_cell_level})
            - $signed({s_cell_black[8], s_cell_black});
        den_neg_v = -den;

        prod_next = prod_reg;
        term_next = term_reg;
        miss_next = miss_reg;
        dz_next = dz_reg;
        den_neg_next = den_neg_reg;
        den_abs_next = den_abs_reg;
        if (cmd.accept) begin
            prod_next = diff_hl * $signed({1'b0, v_sel});
            term_next = $signed({l_cb, 8'b0}) - $signed({{8{l_cb[9]}}, l_cb});
            miss_next = s_cell_black[8] | s_cell_level[8];
            dz_next = (s_cell_black == s_cell_level);
            den_neg_next = den[9];
            den_abs_next = den[9] ? den_neg_v[DEN_W-1:0] : den[DEN_W-1:0];
        end
    end

    // Divider: load magnitude, then one restoring step per cycle
    always_comb begin
        sum = $signed({prod_reg[17], prod_reg}) + $signed({term_reg[17], term_reg});
        sum_neg = -sum;
        sum_mag = sum[18] ? sum_neg[16:0] : sum[16:0];
        trial = {rem_reg, quo_reg[NUM_W-1]};
        trial_ge = (trial >= {1'b0, den_abs_reg});
        trial_diff = trial - {1'b0, den_abs_reg};

        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (cmd.prep) begin
            quo_next = {sum_mag, 8'b0};
            rem_next = '0;
            neg_next = sum[18] ^ den_neg_reg;
        end else if (cmd.step) begin
            quo_next = {quo_reg[NUM_W-2:0], trial_ge};
            rem_next = trial_ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    // Result word: special cases, sign and saturation
    always_comb begin
        quo_neg = -quo_reg;
        m_valid_next = m_valid_reg;
        lut_next = lut_reg;
        miss_out_next = miss_out_reg;
        dz_out_next = dz_out_reg;
        sat_out_next = sat_out_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            m_valid_next = 1'b1;
            miss_out_next = miss_reg;
            dz_out_next = dz_reg & ~miss_reg;
            sat_out_next = 1'b0;
            if (miss_reg) begin
                lut_next = MISSING_V;
            end else if (dz_reg) begin
                lut_next = '0;
            end else if (neg_reg) begin
                if (quo_reg > OUT_MIN_MAG_Q) begin
                    lut_next = OUT_MIN_V;
                    sat_out_next = 1'b1;
                end else begin
                    lut_next = quo_neg[OUT_W-1:0];
                end
            end else begin
                if (quo_reg > OUT_MAX_Q) begin
                    lut_next = OUT_MAX_V;
                    sat_out_next = 1'b1;
                end else begin
                    lut_next = quo_reg[OUT_W-1:0];
                end
            end
        end
    end

    // Control-state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                max_reg[i] <= 8'd0;
                min_reg[i] <= 8'd255;
            end
            m_valid_reg <= 1'b0;
        end else begin
            max_reg <= max_next;
            min_reg <= min_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        term_reg <= term_next;
        miss_reg <= miss_next;
        dz_reg <= dz_next;
        den_neg_reg <= den_neg_next;
        den_abs_reg <= den_abs_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        lut_reg <= lut_next;
        miss_out_reg <= miss_out_next;
        dz_out_reg <= dz_out_next;
        sat_out_reg <= sat_out_next;
    end

    assign status.special = miss_reg | dz_reg;
    assign status.out_free = ~m_valid_reg | m_ready;

    assign m_valid = m_valid_reg;
    assign m_lut_value = lut_reg;
    assign m_cell_missing = miss_out_reg;
    assign m_divide_by_zero = dz_out_reg;
    assign m_saturated = sat_out_reg;

endmodule

// File: hdl/projector_color_lut_entry_unit.sv
// Accumulate, clear and unused opcodes: taken while idle, no result word.
// Compute: prepare, 25 divider steps, then write of the result word (m_valid);
// a missing cell or zero span skips the divider and goes from prepare to write.
// The radix-2 divider is iterative: no new word is taken until the result is written.
// A waiting result word does not block the input but holds the next compute's write.
// Synchronous active-low reset: idle, statistics max 0 and min 255, no result.
module projector_color_lut_entry_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_opcode,
    input  logic [1:0]                s_channel,
    input  logic signed [8:0]         s_measured_level,
    input  logic signed [8:0]         s_cell_black,
    input  logic signed [8:0]         s_cell_level,
    input  logic [pclut_pkg::LEVEL_W-1:0] s_level_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [pclut_pkg::OUT_W-1:0] m_lut_value,
    output logic                      m_cell_missing,
    output logic                      m_divide_by_zero,
    output logic                      m_saturated
);
    import pclut_pkg::*;

    pclut_cmd_t    cmd;
    pclut_status_t status;

    // Sequence control
    pclut_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Statistics, operands, divider and result word
    pclut_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .s_opcode         (s_opcode),
        .s_channel        (s_channel),
        .s_measured_level (s_measured_level),
        .s_cell_black     (s_cell_black),
        .s_cell_level     (s_cell_level),
        .s_level_index    (s_level_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_lut_value      (m_lut_value),
        .m_cell_missing   (m_cell_missing),
        .m_divide_by_zero (m_divide_by_zero),
        .m_saturated      (m_saturated)
    );

`ifndef ASSERT_OFF
    // A compute word blocks the input until its result is written
    a_busy_after_compute: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_opcode == OP_COMPUTE |=> !s_ready)
        else $error("input ready right after compute word");

    // Flags are exclusive
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $countones({m_cell_missing, m_divide_by_zero, m_saturated}) <= 1)
        else $error("result flags not exclusive");

    // Missing cell gives -1.0
    a_missing_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_cell_missing |-> m_lut_value == MISSING_V)
        else $error("missing cell value wrong");

    // Zero denominator gives 0
    a_dz_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_divide_by_zero |-> m_lut_value == '0)
        else $error("zero denominator value wrong");
`endif

endmodule
